FILE: design/pcm_frame_level_dbfs_macros.svh
// Assertion macros for the frame level meter.
// Included by the RTL module that carries concurrent assertions; no dependencies.
`ifndef PCM_FRAME_LEVEL_DBFS_MACROS_SVH
`define PCM_FRAME_LEVEL_DBFS_MACROS_SVH

`ifndef NO_ASSERTIONS
// Assertion that is checked only while the block is out of reset.
`define PFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion that is checked at every clock edge, reset included.
`define PFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFL_ASSERT(lbl, clk, rstn, prop, msg)
`define PFL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/pfl_pkg.sv
// Package for the frame level meter: transaction types, limits and dB threshold table.
// No dependencies.
`timescale 1ns / 1ps

package pfl_pkg;

  // Frame length at which accumulation saturates.
  localparam int unsigned MaxFrameSamples = 65536;
  // Number of whole-dB steps covered by the threshold table.
  localparam int unsigned DbSteps = 90;

  // Input transaction: one PCM sample and its end-of-frame flag.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } in_item_t;

  // Output transaction: frame level and mean amplitude.
  typedef struct packed {
    logic signed [7:0] level_db;
    logic [15:0]       mean_amplitude;
  } out_item_t;

  // floor(32768 * 10^(-k/20)) for k = 1..90; zero outside that range.
  function automatic logic [15:0] db_threshold(input logic [6:0] k);
    logic [15:0] thr;
    unique case (k)
      7'd1:  thr = 16'd29204;  7'd2:  thr = 16'd26028;  7'd3:  thr = 16'd23197;
      7'd4:  thr = 16'd20675;  7'd5:  thr = 16'd18426;  7'd6:  thr = 16'd16422;
      7'd7:  thr = 16'd14636;  7'd8:  thr = 16'd13045;  7'd9:  thr = 16'd11626;
      7'd10: thr = 16'd10362;  7'd11: thr = 16'd9235;   7'd12: thr = 16'd8230;
      7'd13: thr = 16'd7335;   7'd14: thr = 16'd6538;   7'd15: thr = 16'd5827;
      7'd16: thr = 16'd5193;   7'd17: thr = 16'd4628;   7'd18: thr = 16'd4125;
      7'd19: thr = 16'd3676;   7'd20: thr = 16'd3276;   7'd21: thr = 16'd2920;
      7'd22: thr = 16'd2602;   7'd23: thr = 16'd2319;   7'd24: thr = 16'd2067;
      7'd25: thr = 16'd1842;   7'd26: thr = 16'd1642;   7'd27: thr = 16'd1463;
      7'd28: thr = 16'd1304;   7'd29: thr = 16'd1162;   7'd30: thr = 16'd1036;
      7'd31: thr = 16'd923;    7'd32: thr = 16'd823;    7'd33: thr = 16'd733;
      7'd34: thr = 16'd653;    7'd35: thr = 16'd582;    7'd36: thr = 16'd519;
      7'd37: thr = 16'd462;    7'd38: thr = 16'd412;    7'd39: thr = 16'd367;
      7'd40: thr = 16'd327;    7'd41: thr = 16'd292;    7'd42: thr = 16'd260;
      7'd43: thr = 16'd231;    7'd44: thr = 16'd206;    7'd45: thr = 16'd184;
      7'd46: thr = 16'd164;    7'd47: thr = 16'd146;    7'd48: thr = 16'd130;
      7'd49: thr = 16'd116;    7'd50: thr = 16'd103;    7'd51: thr = 16'd92;
      7'd52: thr = 16'd82;     7'd53: thr = 16'd73;     7'd54: thr = 16'd65;
      7'd55: thr = 16'd58;     7'd56: thr = 16'd51;     7'd57: thr = 16'd46;
      7'd58: thr = 16'd41;     7'd59: thr = 16'd36;     7'd60: thr = 16'd32;
      7'd61: thr = 16'd29;     7'd62: thr = 16'd26;     7'd63: thr = 16'd23;
      7'd64: thr = 16'd20;     7'd65: thr = 16'd18;     7'd66: thr = 16'd16;
      7'd67: thr = 16'd14;     7'd68: thr = 16'd13;     7'd69: thr = 16'd11;
      7'd70: thr = 16'd10;     7'd71: thr = 16'd9;      7'd72: thr = 16'd8;
      7'd73: thr = 16'd7;      7'd74: thr = 16'd6;      7'd75: thr = 16'd5;
      7'd76: thr = 16'd5;      7'd77: thr = 16'd4;      7'd78: thr = 16'd4;
      7'd79: thr = 16'd3;      7'd80: thr = 16'd3;      7'd81: thr = 16'd2;
      7'd82: thr = 16'd2;      7'd83: thr = 16'd2;      7'd84: thr = 16'd2;
      7'd85: thr = 16'd1;      7'd86: thr = 16'd1;      7'd87: thr = 16'd1;
      7'd88: thr = 16'd1;      7'd89: thr = 16'd1;      7'd90: thr = 16'd1;
      default: thr = 16'd0;
    endcase
    return thr;
  endfunction

endpackage

FILE: design/pcm_frame_level_dbfs.sv
// Frame level meter top level: accumulator, shared divide/compare unit and sequencer.
// Depends on pfl_pkg and pcm_frame_level_dbfs_macros.svh.
//
// Usage:
//   Samples arrive on the input channel (in_valid_i / in_stall_o, payload in_data_i),
//   one signed 16-bit sample per transaction. A sample without last_sample is absorbed
//   directly into the accumulator, so samples inside a frame stream at one per cycle. Once 65536
//   samples are held, further samples of the frame are ignored.
//   The sample flagged last_sample ends the frame. The block then stalls its input
//   and runs the mean and level through one shared 18-bit subtractor: restoring
//   division (one quotient bit per cycle), then a binary search over the 90-entry
//   dB threshold table. The result is loaded into the output register once the
//   output slot is free, and the input takes samples again in the same cycle.
//   The output channel (out_valid_o / out_stall_i, payload out_data_o) holds its
//   transaction while stalled. A new frame may accumulate meanwhile; if its result
//   is ready before the old one is taken, the block waits with its input stalled.
//   Reset clears the accumulator, the sample count, the sequencer and the output
//   valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`include "pcm_frame_level_dbfs_macros.svh"

module pcm_frame_level_dbfs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfl_pkg::in_item_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfl_pkg::out_item_t out_data_o
);

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSrch = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] sum_q, sum_d;
  logic [16:0] cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] div_q, div_d;
  logic [6:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  pfl_pkg::out_item_t out_q, out_d;

  logic        in_accept;
  logic [16:0] mag;
  logic        cnt_room;
  logic [31:0] sum_next;
  logic [16:0] cnt_next;
  logic [17:0] partial;
  logic [17:0] op_a, op_b;
  logic [18:0] diff;
  logic        ge;
  logic [6:0]  trial;
  logic [15:0] thr;
  logic        slot_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Magnitude of the sample; the most negative code maps to 32768.
  assign mag = in_data_i.sample[15] ? (17'h10000 - {1'b0, in_data_i.sample})
                                    : {1'b0, in_data_i.sample};

  // Accumulate unless the frame has reached its sample limit.
  assign cnt_room = (cnt_q < 17'(pfl_pkg::MaxFrameSamples));
  assign sum_next = cnt_room ? (sum_q + {15'd0, mag}) : sum_q;
  assign cnt_next = cnt_room ? (cnt_q + 17'd1) : cnt_q;

  // Binary search candidate and its table threshold.
  assign trial = idx_q | (7'd1 << step_q[2:0]);
  assign thr   = pfl_pkg::db_threshold(trial);

  // Shared subtractor: division step or threshold compare.
  assign partial = {rem_q, quo_q[31]};
  always_comb begin
    if (state_q == StSrch) begin
      op_a = {2'd0, thr};
      op_b = {2'd0, quo_q[15:0]};
    end else begin
      op_a = partial;
      op_b = {1'b0, div_q};
    end
  end
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = !diff[18];

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_d       = div_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (in_data_i.last_sample) begin
            quo_d   = sum_next;
            div_d   = cnt_next;
            rem_d   = 17'd0;
            step_d  = 5'd31;
            sum_d   = 32'd0;
            cnt_d   = 17'd0;
            state_d = StDiv;
          end else begin
            sum_d = sum_next;
            cnt_d = cnt_next;
          end
        end
      end
      StDiv: begin
        rem_d = ge ? diff[16:0] : partial[16:0];
        quo_d = {quo_q[30:0], ge};
        if (step_q == 5'd0) begin
          step_d  = 5'd6;
          idx_d   = 7'd0;
          state_d = StSrch;
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      StSrch: begin
        // A zero mean reports 0 dB, so no step is taken for it.
        if (ge && (quo_q[15:0] != 16'd0)) begin
          idx_d = trial;
        end
        if (step_q == 5'd0) begin
          state_d = StOut;
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      StOut: begin
        if (slot_free) begin
          out_d.level_db       = -$signed({1'b0, idx_q});
          out_d.mean_amplitude = quo_q[15:0];
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= 5'd0;
      sum_q       <= 32'd0;
      cnt_q       <= 17'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    idx_q <= idx_d;
    out_q <= out_d;
  end

  // Assertions.
  `PFL_ASSERT(a_last_stalls, clk_i, rst_ni, in_accept && in_data_i.last_sample |=> in_stall_o, "last sample did not start the frame computation")
  `PFL_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == StOut, "result appeared outside the output step")
  `PFL_ASSERT(a_mean_range, clk_i, rst_ni, out_valid_q |-> out_q.mean_amplitude <= 16'd32768, "mean amplitude above full scale")
  `PFL_ASSERT(a_silent_level, clk_i, rst_ni, out_valid_q && out_q.mean_amplitude == 16'd0 |-> out_q.level_db == 8'sd0, "silent frame gave a nonzero level")
  `PFL_ASSERT_ALWAYS(a_cnt_limit, clk_i, !rst_ni || cnt_q <= 17'(pfl_pkg::MaxFrameSamples), "sample count beyond frame limit")

endmodule
